// ===== src/cpcc_pkg.sv =====
package cpcc_pkg;

    localparam int CREDIT_BITS_DEF = 32;
    localparam int CFG_IDX_W       = 1;
    localparam int CFG_DATA_W      = 16;
    localparam int GEN_W           = 32;
    localparam int RANK_W          = 16;
    localparam int OUT_CREDIT_W    = 32;
    // Per-packet amount is gen_symbols + redundancy and needs one extra bit.
    localparam int PKT_W           = CFG_DATA_W + 1;
    localparam int PROD_W          = RANK_W + PKT_W;

    localparam logic [CFG_IDX_W-1:0]  CFG_GEN_SYMBOLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0]  CFG_REDUNDANCY  = 1'b1;

    localparam logic [CFG_DATA_W-1:0] GEN_SYMBOLS_RST = 16'd16;
    localparam logic [CFG_DATA_W-1:0] REDUNDANCY_RST  = 16'd0;
    localparam logic [GEN_W-1:0]      GEN_START       = 32'd1;
    localparam logic [RANK_W-1:0]     RANK_MAX        = 16'hFFFF;

    typedef enum logic [1:0] {
        CMD_PUT      = 2'd0,
        CMD_GET      = 2'd1,
        CMD_FEEDBACK = 2'd2,
        CMD_FLUSH    = 2'd3
    } t_cmd;

    typedef struct packed {
        logic capture;
        logic exec;
        logic add_prod;
        logic div_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic need_mul;
        logic need_div;
        logic div_last;
    } t_dp_stat;

endpackage

// ===== src/cpcc_ctrl.sv =====
module cpcc_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    input  cpcc_pkg::t_dp_stat i_stat,
    output cpcc_pkg::t_dp_cmd  o_cmd
);
    import cpcc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EXEC = 5'b00010,
        S_ADD  = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || !i_stall;
    assign o_stall   = (r_state != S_IDLE);
    assign o_valid   = r_out_valid;

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.need_mul) begin
                    n_state = S_ADD;
                end else if (i_stat.need_div) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_ADD: begin
                o_cmd.add_prod = 1'b1;
                n_state        = S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // An accepted item always leads into the execute step on the next cycle.
    a_capture_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (o_cmd.exec && o_stall))
        else $error("accepted item did not enter execute");

    // A waiting result is never overwritten by the next one.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result was dropped");

    // The saturating add of the product leads into the done state on the next cycle.
    a_add_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |=> (r_state == S_DONE))
        else $error("product add did not finish in one cycle");

endmodule

// ===== src/cpcc_dp.sv =====
module cpcc_dp #(
    parameter int CREDIT_BITS = cpcc_pkg::CREDIT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [cpcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cpcc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  cpcc_pkg::t_cmd                      i_cmd,
    input  logic [cpcc_pkg::GEN_W-1:0]          i_fb_generation,
    input  logic [cpcc_pkg::RANK_W-1:0]         i_fb_rank,
    input  logic                                i_fb_short,
    input  cpcc_pkg::t_dp_cmd                   i_ctl,
    output cpcc_pkg::t_dp_stat                  o_stat,
    output logic                                o_status,
    output logic                                o_has_coded,
    output logic                                o_gen_full,
    output logic                                o_gen_complete,
    output logic [cpcc_pkg::GEN_W-1:0]          o_hdr_generation,
    output logic [cpcc_pkg::RANK_W-1:0]         o_hdr_rank,
    output logic [cpcc_pkg::OUT_CREDIT_W-1:0]   o_credit
);
    import cpcc_pkg::*;

    localparam int ADD_W = ((CREDIT_BITS > PROD_W) ? CREDIT_BITS : PROD_W) + 1;
    localparam int CNT_W = $clog2(CREDIT_BITS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CREDIT_BITS - 1);
    localparam logic [ADD_W-1:0] CREDIT_MAX = ADD_W'({CREDIT_BITS{1'b1}});

    // Configuration
    logic [CFG_DATA_W-1:0]  r_gen_symbols;
    logic [CFG_DATA_W-1:0]  r_redundancy;

    // Sender state
    logic [GEN_W-1:0]       r_generation;
    logic [RANK_W-1:0]      r_rank;
    logic [CREDIT_BITS-1:0] r_credit;
    logic                   r_full;
    logic                   r_complete;
    logic                   r_status;

    // Latched item
    t_cmd                   r_cmd;
    logic [GEN_W-1:0]       r_fb_gen;
    logic [RANK_W-1:0]      r_fb_rank;
    logic                   r_fb_short;

    // Multiply and divide working registers
    logic [PROD_W-1:0]      r_prod;
    logic [CREDIT_BITS-1:0] r_div_sh;
    logic [CFG_DATA_W-1:0]  r_rem;
    logic [CNT_W-1:0]       r_cnt;

    logic [PKT_W-1:0]       per_packet;
    logic [ADD_W-1:0]       add_amt;
    logic [ADD_W-1:0]       add_sum;
    logic [CREDIT_BITS-1:0] add_credit;
    logic [CREDIT_BITS-1:0] sub_credit;
    logic [RANK_W-1:0]      put_base;
    logic [RANK_W-1:0]      put_rank;
    logic                   fb_ok;
    logic [RANK_W-1:0]      rank_gap;
    logic [CFG_DATA_W:0]    div_try;
    logic [CFG_DATA_W:0]    div_diff;
    logic [CFG_DATA_W-1:0]  n_rem;

    assign per_packet = PKT_W'(r_gen_symbols) + PKT_W'(r_redundancy);

    // Shared saturating adder: per-packet credit or the registered product.
    assign add_amt    = i_ctl.add_prod ? ADD_W'(r_prod) : ADD_W'(per_packet);
    assign add_sum    = ADD_W'(r_credit) + add_amt;
    assign add_credit = (add_sum > CREDIT_MAX) ? {CREDIT_BITS{1'b1}}
                                               : add_sum[CREDIT_BITS-1:0];

    assign sub_credit = (CREDIT_BITS'(r_gen_symbols) >= r_credit) ? '0
                                                                  : r_credit
                                                                    - CREDIT_BITS'(r_gen_symbols);

    // A put into a completed generation opens the next one first.
    assign put_base = r_complete ? '0 : r_rank;
    assign put_rank = (put_base != RANK_MAX) ? put_base + 1'b1 : put_base;

    assign fb_ok    = (r_cmd == CMD_FEEDBACK) && !r_fb_short && (r_fb_gen == r_generation);
    assign rank_gap = r_rank - r_fb_rank;

    assign o_stat.need_mul = fb_ok && (r_fb_rank < r_rank);
    assign o_stat.need_div = fb_ok && (r_fb_rank >= r_rank) && (r_gen_symbols != '0);
    assign o_stat.div_last = (r_cnt == CNT_LAST);

    // One restoring step of the modulo: the remainder stays below the divisor.
    assign div_try  = {r_rem, r_div_sh[CREDIT_BITS-1]};
    assign div_diff = div_try - (CFG_DATA_W + 1)'(r_gen_symbols);
    assign n_rem    = (div_try >= (CFG_DATA_W + 1)'(r_gen_symbols)) ? div_diff[CFG_DATA_W-1:0]
                                                                   : div_try[CFG_DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_symbols <= GEN_SYMBOLS_RST;
            r_redundancy  <= REDUNDANCY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GEN_SYMBOLS: r_gen_symbols <= i_cfg_data;
                CFG_REDUNDANCY:  r_redundancy  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_cmd      <= i_cmd;
            r_fb_gen   <= i_fb_generation;
            r_fb_rank  <= i_fb_rank;
            r_fb_short <= i_fb_short;
        end
        if (i_ctl.exec) begin
            r_prod   <= PROD_W'(rank_gap) * PROD_W'(per_packet);
            r_div_sh <= r_credit;
            r_rem    <= '0;
            r_cnt    <= '0;
        end else if (i_ctl.div_step) begin
            r_div_sh <= r_div_sh << 1;
            r_rem    <= n_rem;
            r_cnt    <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_generation <= GEN_START;
            r_rank       <= '0;
            r_credit     <= '0;
            r_full       <= 1'b0;
            r_complete   <= 1'b0;
            r_status     <= 1'b0;
        end else if (i_ctl.exec) begin
            r_status <= (r_cmd == CMD_FEEDBACK) && r_fb_short;
            case (r_cmd)
                CMD_PUT: begin
                    if (r_complete) begin
                        r_generation <= r_generation + 1'b1;
                        r_complete   <= 1'b0;
                    end
                    r_rank   <= put_rank;
                    r_credit <= add_credit;
                    if (put_rank == r_gen_symbols) begin
                        r_full <= 1'b1;
                    end else if (r_complete) begin
                        r_full <= 1'b0;
                    end
                end
                CMD_GET: begin
                    r_credit <= sub_credit;
                end
                CMD_FEEDBACK: begin
                    if (fb_ok && (r_fb_rank >= r_rank)) begin
                        r_complete <= 1'b1;
                        r_full     <= 1'b0;
                    end
                end
                CMD_FLUSH: begin
                    r_credit <= add_credit;
                    r_full   <= 1'b1;
                end
                default: begin
                end
            endcase
        end else if (i_ctl.add_prod) begin
            r_credit <= add_credit;
        end else if (i_ctl.div_step && o_stat.div_last) begin
            r_credit <= CREDIT_BITS'(n_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            o_status         <= r_status;
            o_has_coded      <= (r_credit >= CREDIT_BITS'(r_gen_symbols));
            o_gen_full       <= r_full;
            o_gen_complete   <= r_complete;
            o_hdr_generation <= r_generation;
            o_hdr_rank       <= r_rank;
            o_credit         <= OUT_CREDIT_W'(r_credit);
        end
    end

    // Putting a source packet never lowers the credit; the add saturates at the top.
    a_put_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.exec && (r_cmd == CMD_PUT)) |=> (r_credit >= $past(r_credit)))
        else $error("credit fell on put source");

endmodule

// ===== src/coded_packet_credit_control.sv =====
// Each item is captured, then executed. A feedback that grants credit for missing
// rank adds a 16 x 17 multiply product in a further add step; one that completes
// the generation with nonzero gen_symbols reduces the credit modulo gen_symbols one
// bit per cycle. The result is registered once the output slot is free, and the
// next item is taken in the cycle after that. Synchronous active-low reset restores
// generation 1, rank and credit 0, and clears the full, complete and status flags.
module coded_packet_credit_control #(
    parameter int CREDIT_BITS = cpcc_pkg::CREDIT_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cpcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [cpcc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [1:0]                          i_cmd,
    input  logic [cpcc_pkg::GEN_W-1:0]          i_fb_generation,
    input  logic [cpcc_pkg::RANK_W-1:0]         i_fb_rank,
    input  logic                                i_fb_short,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_status,
    output logic                                o_has_coded,
    output logic                                o_gen_full,
    output logic                                o_gen_complete,
    output logic [cpcc_pkg::GEN_W-1:0]          o_hdr_generation,
    output logic [cpcc_pkg::RANK_W-1:0]         o_hdr_rank,
    output logic [cpcc_pkg::OUT_CREDIT_W-1:0]   o_credit
);
    import cpcc_pkg::*;

    t_dp_cmd  ctl;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    cpcc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (ctl)
    );

    cpcc_dp #(
        .CREDIT_BITS (CREDIT_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_cmd            (t_cmd'(i_cmd)),
        .i_fb_generation  (i_fb_generation),
        .i_fb_rank        (i_fb_rank),
        .i_fb_short       (i_fb_short),
        .i_ctl            (ctl),
        .o_stat           (stat),
        .o_status         (o_status),
        .o_has_coded      (o_has_coded),
        .o_gen_full       (o_gen_full),
        .o_gen_complete   (o_gen_complete),
        .o_hdr_generation (o_hdr_generation),
        .o_hdr_rank       (o_hdr_rank),
        .o_credit         (o_credit)
    );

endmodule

// ===== tb/coded_packet_credit_control_test.sv =====
`timescale 1ns / 1ps

module coded_packet_credit_control_test;
    import cpcc_pkg::*;

    localparam int unsigned RUN_LIMIT = 3_000_000;
    localparam logic [63:0] CREDIT_LIMIT = (64'd1 << CREDIT_BITS_DEF) - 64'd1;

    typedef struct packed {
        t_cmd        cmd;
        logic [31:0] fb_generation;
        logic [15:0] fb_rank;
        logic        fb_short;
    } credit_event_t;

    typedef struct packed {
        logic        status;
        logic        has_coded;
        logic        gen_full;
        logic        gen_complete;
        logic [31:0] hdr_generation;
        logic [15:0] hdr_rank;
        logic [31:0] credit;
    } credit_result_t;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_valid;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_DATA_W-1:0]   i_cfg_data;
    logic                    i_valid;
    logic                    o_stall;
    logic [1:0]              i_cmd;
    logic [GEN_W-1:0]        i_fb_generation;
    logic [RANK_W-1:0]       i_fb_rank;
    logic                    i_fb_short;
    logic                    o_valid;
    logic                    i_stall;
    logic                    o_status;
    logic                    o_has_coded;
    logic                    o_gen_full;
    logic                    o_gen_complete;
    logic [GEN_W-1:0]        o_hdr_generation;
    logic [RANK_W-1:0]       o_hdr_rank;
    logic [OUT_CREDIT_W-1:0] o_credit;

    // Predicted state of the sender control.
    logic [31:0] ctl_generation;
    logic [15:0] ctl_rank;
    logic [63:0] ctl_credit;
    logic        ctl_full;
    logic        ctl_complete;
    logic [15:0] cfg_gen_symbols;
    logic [15:0] cfg_redundancy;

    credit_result_t expected_results[$];
    int unsigned    mismatch_count;
    int unsigned    cycle_count;
    int unsigned    sender_idle_pct;
    int unsigned    receiver_idle_pct;
    int unsigned    hold_off_cycles;

    coded_packet_credit_control u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_cmd            (i_cmd),
        .i_fb_generation  (i_fb_generation),
        .i_fb_rank        (i_fb_rank),
        .i_fb_short       (i_fb_short),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_status         (o_status),
        .o_has_coded      (o_has_coded),
        .o_gen_full       (o_gen_full),
        .o_gen_complete   (o_gen_complete),
        .o_hdr_generation (o_hdr_generation),
        .o_hdr_rank       (o_hdr_rank),
        .o_credit         (o_credit)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("coded_packet_credit_control_test: FAIL");
            $finish;
        end
    end

    // The output side stalls at random, or for a whole stretch when a hold-off is requested.
    always @(negedge i_clk) begin
        if (hold_off_cycles != 0) begin
            i_stall <= 1'b1;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < receiver_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        credit_result_t got;
        credit_result_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_status, o_has_coded, o_gen_full, o_gen_complete,
                   o_hdr_generation, o_hdr_rank, o_credit};
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: gen %0d rank %0d credit %0d",
                             got.hdr_generation, got.hdr_rank, got.credit);
            end else begin
                want = expected_results.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"mismatch: status %b/%b has_coded %b/%b full %b/%b ",
                                  "complete %b/%b gen %0d/%0d rank %0d/%0d credit %0d/%0d ",
                                  "(expected/actual)"},
                                 want.status, got.status, want.has_coded, got.has_coded,
                                 want.gen_full, got.gen_full,
                                 want.gen_complete, got.gen_complete,
                                 want.hdr_generation, got.hdr_generation,
                                 want.hdr_rank, got.hdr_rank, want.credit, got.credit);
                end
            end
        end
    end

    function automatic void grant_credit(logic [63:0] amount);
        if (amount > CREDIT_LIMIT - ctl_credit)
            ctl_credit = CREDIT_LIMIT;
        else
            ctl_credit = ctl_credit + amount;
    endfunction

    function automatic credit_result_t predict_event(credit_event_t ev);
        credit_result_t res;
        logic [63:0]    per_packet;
        per_packet = 64'(cfg_gen_symbols) + 64'(cfg_redundancy);
        res.status = 1'b0;
        case (ev.cmd)
            CMD_PUT: begin
                if (ctl_complete) begin
                    ctl_generation = ctl_generation + 32'd1;
                    ctl_rank = '0;
                    ctl_complete = 1'b0;
                    ctl_full = 1'b0;
                end
                if (ctl_rank != RANK_MAX)
                    ctl_rank = ctl_rank + 16'd1;
                grant_credit(per_packet);
                if (ctl_rank == cfg_gen_symbols)
                    ctl_full = 1'b1;
            end
            CMD_GET: begin
                if (64'(cfg_gen_symbols) >= ctl_credit)
                    ctl_credit = '0;
                else
                    ctl_credit = ctl_credit - 64'(cfg_gen_symbols);
            end
            CMD_FEEDBACK: begin
                if (ev.fb_short) begin
                    res.status = 1'b1;
                end else if (ev.fb_generation == ctl_generation) begin
                    if (ev.fb_rank >= ctl_rank) begin
                        ctl_complete = 1'b1;
                        if (cfg_gen_symbols != 0)
                            ctl_credit = ctl_credit % 64'(cfg_gen_symbols);
                        ctl_full = 1'b0;
                    end else begin
                        grant_credit(64'(ctl_rank - ev.fb_rank) * per_packet);
                    end
                end
            end
            default: begin
                grant_credit(per_packet);
                ctl_full = 1'b1;
            end
        endcase
        res.has_coded      = (ctl_credit >= 64'(cfg_gen_symbols));
        res.gen_full       = ctl_full;
        res.gen_complete   = ctl_complete;
        res.hdr_generation = ctl_generation;
        res.hdr_rank       = ctl_rank;
        res.credit         = ctl_credit[31:0];
        return res;
    endfunction

    // Mostly well-formed traffic: feedback usually names the current generation
    // and often reports partial rank, so generations fill up before completing.
    function automatic credit_event_t make_random_event();
        credit_event_t ev;
        int unsigned   roll;
        roll = $urandom_range(0, 99);
        ev.fb_generation = $urandom();
        ev.fb_rank = 16'($urandom());
        ev.fb_short = 1'($urandom());
        if (roll < 45) begin
            ev.cmd = CMD_PUT;
        end else if (roll < 68) begin
            ev.cmd = CMD_GET;
        end else if (roll < 90) begin
            ev.cmd = CMD_FEEDBACK;
            ev.fb_short = ($urandom_range(0, 99) < 8);
            roll = $urandom_range(0, 99);
            if (roll < 80)
                ev.fb_generation = ctl_generation;
            else if (roll < 90)
                ev.fb_generation = ctl_generation + 32'd1;
            roll = $urandom_range(0, 99);
            if (roll < 30)
                ev.fb_rank = (ctl_rank > RANK_MAX - 16'd2) ? RANK_MAX :
                             ctl_rank + 16'($urandom_range(0, 2));
            else if (roll < 35)
                ev.fb_rank = RANK_MAX;
            else if (roll < 85)
                ev.fb_rank = 16'($urandom_range(0, ctl_rank));
        end else begin
            ev.cmd = CMD_FLUSH;
        end
        return ev;
    endfunction

    task automatic send_event(input credit_event_t ev);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cmd           <= ev.cmd;
        i_fb_generation <= ev.fb_generation;
        i_fb_rank       <= ev.fb_rank;
        i_fb_short      <= ev.fb_short;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        expected_results.push_back(predict_event(ev));
    endtask

    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        if (index == CFG_GEN_SYMBOLS)
            cfg_gen_symbols = value;
        else
            cfg_redundancy = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic test_command_basics();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        // Spending credit that is not there stops at zero.
        send_event('{CMD_GET, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_FEEDBACK, 32'hFFFF_FFFF, 16'hFFFF, 1'b1});
        send_event('{CMD_PUT, 32'hFFFF_FFFF, 16'hFFFF, 1'b1});
        send_event('{CMD_PUT, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_FEEDBACK, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_FEEDBACK, 32'hFFFF_FFFF, 16'h0, 1'b0});
        send_event('{CMD_FEEDBACK, ctl_generation, 16'h0, 1'b0});
        send_event('{CMD_GET, 32'hFFFF_FFFF, 16'hFFFF, 1'b1});
        send_event('{CMD_FLUSH, 32'hFFFF_FFFF, 16'hFFFF, 1'b1});
        send_event('{CMD_FEEDBACK, ctl_generation, 16'hFFFF, 1'b0});
        send_event('{CMD_GET, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_PUT, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_FEEDBACK, 32'h0, 16'h0, 1'b1});
    endtask

    task automatic test_register_corners();
        wait_for_results();
        write_register(CFG_GEN_SYMBOLS, 16'd3);
        write_register(CFG_REDUNDANCY, 16'hFFFF);
        send_event('{CMD_FEEDBACK, ctl_generation, RANK_MAX, 1'b0});
        repeat (4)
            send_event('{CMD_PUT, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_GET, 32'h0, 16'h0, 1'b0});
        // Rank is now past the generation size, so put source must not set full.
        wait_for_results();
        write_register(CFG_GEN_SYMBOLS, 16'd1);
        send_event('{CMD_PUT, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_FLUSH, 32'h0, 16'h0, 1'b0});
        // A zero generation size leaves the credit untouched on completion.
        wait_for_results();
        write_register(CFG_GEN_SYMBOLS, 16'd0);
        send_event('{CMD_GET, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_FEEDBACK, ctl_generation, 16'hFFFF, 1'b0});
        send_event('{CMD_PUT, 32'h0, 16'h0, 1'b0});
        wait_for_results();
        write_register(CFG_GEN_SYMBOLS, 16'hFFFF);
        write_register(CFG_REDUNDANCY, 16'd0);
        send_event('{CMD_PUT, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_GET, 32'h0, 16'h0, 1'b0});
    endtask

    task automatic test_random_traffic(input int unsigned n_items,
                                       input logic [15:0] gen_symbols,
                                       input logic [15:0] redundancy,
                                       input int unsigned send_idle,
                                       input int unsigned recv_idle);
        wait_for_results();
        write_register(CFG_GEN_SYMBOLS, gen_symbols);
        write_register(CFG_REDUNDANCY, redundancy);
        sender_idle_pct = send_idle;
        receiver_idle_pct = recv_idle;
        repeat (n_items)
            send_event(make_random_event());
    endtask

    task automatic test_output_backpressure();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        hold_off_cycles = 400;
        repeat (40)
            send_event(make_random_event());
    endtask

    // Builds a deep rank, then repeats partial feedback so that each one grants
    // the missing rank at the largest per-item amount until the credit pins at
    // its maximum.
    task automatic test_credit_saturation();
        wait_for_results();
        write_register(CFG_GEN_SYMBOLS, 16'hFFFF);
        write_register(CFG_REDUNDANCY, 16'hFFFF);
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        send_event('{CMD_FEEDBACK, ctl_generation, RANK_MAX, 1'b0});
        repeat (180)
            send_event('{CMD_PUT, 32'h0, 16'h0, 1'b0});
        repeat (190)
            send_event('{CMD_FEEDBACK, ctl_generation, 16'h0, 1'b0});
        send_event('{CMD_FLUSH, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_GET, 32'h0, 16'h0, 1'b0});
        send_event('{CMD_FEEDBACK, ctl_generation, RANK_MAX, 1'b0});
        send_event('{CMD_PUT, 32'h0, 16'h0, 1'b0});
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_GEN_SYMBOLS;
        i_cfg_data      = '0;
        i_valid         = 1'b0;
        i_cmd           = CMD_PUT;
        i_fb_generation = '0;
        i_fb_rank       = '0;
        i_fb_short      = 1'b0;
        i_stall         = 1'b0;
        mismatch_count    = 0;
        cycle_count       = 0;
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_off_cycles   = 0;
        ctl_generation  = GEN_START;
        ctl_rank        = '0;
        ctl_credit      = '0;
        ctl_full        = 1'b0;
        ctl_complete    = 1'b0;
        cfg_gen_symbols = GEN_SYMBOLS_RST;
        cfg_redundancy  = REDUNDANCY_RST;

        repeat (10)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_command_basics();
        test_register_corners();
        test_random_traffic(520, 16'($urandom_range(2, 12)), 16'($urandom_range(0, 5)),
                            38, 69);
        test_random_traffic(520, 16'd1, 16'hFFFF, 69, 38);
        test_random_traffic(500, 16'($urandom_range(1, 24)), 16'($urandom()), 0, 0);
        test_output_backpressure();
        test_credit_saturation();

        wait_for_results();
        repeat (CREDIT_BITS_DEF + 8)
            @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("coded_packet_credit_control_test: PASS");
        end else begin
            $display("coded_packet_credit_control_test: FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/cpcc_pkg.sv
src/cpcc_ctrl.sv
src/cpcc_dp.sv
src/coded_packet_credit_control.sv
tb/coded_packet_credit_control_test.sv
